// ----- hdl/prqs_pkg.sv -----
// shared types and constants for the priority ready-queue scheduler
package prqs_pkg;

    localparam int TASK_SLOTS_DEF    = 8;
    localparam int IDLE_PRIORITY_DEF = 255;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_DELAY  = 2'd1,
        MODE_RUN    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_NO_SLOT     = 2'd1,
        STAT_ZERO_DELAY  = 2'd2,
        STAT_QUEUE_EMPTY = 2'd3
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic dispatch;
        logic ins_read;
        logic ins_step;
        logic dly_read;
        logic dly_step;
        logic sched;
        logic out_load;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic create_ok;
        logic delay_ok;
        logic is_run;
        logic idx_zero;
        logic shift_on;
        logic dly_last;
        logic started;
        logic out_free;
    } stat_t;

endpackage

// ----- hdl/prqs_ctrl.sv -----
// controller state machine of the priority ready-queue scheduler
module prqs_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  prqs_pkg::stat_t stat,
    output prqs_pkg::cmd_t  cmd
);
    import prqs_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_DISPATCH = 8'b0000_0010,
        ST_INS_READ = 8'b0000_0100,
        ST_INS_STEP = 8'b0000_1000,
        ST_DLY_READ = 8'b0001_0000,
        ST_DLY_STEP = 8'b0010_0000,
        ST_SCHED    = 8'b0100_0000,
        ST_OUT      = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                cmd.dispatch = 1'b1;
                if (stat.create_ok) begin
                    state_next = ST_INS_READ;
                end else if (stat.delay_ok) begin
                    state_next = ST_DLY_READ;
                end else if (stat.is_run) begin
                    state_next = ST_SCHED;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_INS_READ: begin
                cmd.ins_read = 1'b1;
                if (stat.idx_zero) begin
                    state_next = stat.started ? ST_SCHED : ST_OUT;
                end else begin
                    state_next = ST_INS_STEP;
                end
            end
            ST_INS_STEP: begin
                cmd.ins_step = 1'b1;
                if (stat.shift_on) begin
                    state_next = ST_INS_READ;
                end else begin
                    state_next = stat.started ? ST_SCHED : ST_OUT;
                end
            end
            ST_DLY_READ: begin
                cmd.dly_read = 1'b1;
                state_next   = ST_DLY_STEP;
            end
            ST_DLY_STEP: begin
                cmd.dly_step = 1'b1;
                state_next   = stat.dly_last ? ST_OUT : ST_DLY_READ;
            end
            ST_SCHED: begin
                cmd.sched  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                cmd.out_load = stat.out_free;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

endmodule

// ----- hdl/prqs_datapath.sv -----
// datapath of the priority ready-queue scheduler: queue memory, task state, result register
module prqs_datapath #(
    parameter int TASK_SLOTS    = prqs_pkg::TASK_SLOTS_DEF,
    parameter int IDLE_PRIORITY = prqs_pkg::IDLE_PRIORITY_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  prqs_pkg::cmd_t                     cmd,
    output prqs_pkg::stat_t                    stat,
    input  logic [prqs_pkg::IN_TDATA_W-1:0]    in_tdata,
    input  logic [prqs_pkg::IN_TUSER_W-1:0]    in_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [prqs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import prqs_pkg::*;

    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
    localparam int ENT_W  = SLOT_W + 8;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TASK_SLOTS);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
    localparam logic [7:0]       IDLE_C  = 8'(IDLE_PRIORITY);

    // latched request
    mode_t       mode_reg;
    logic [7:0]  prio_reg;
    logic [15:0] ticks_reg;
    logic [7:0]  nest_reg;

    // queue bookkeeping; queue entry zero lives in the head registers
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [SLOT_W-1:0] head_slot_reg, head_slot_next;
    logic [7:0]        head_prio_reg, head_prio_next;
    logic [SLOT_W-1:0] new_slot_reg, new_slot_next;

    // running task
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic [7:0]        cur_prio_reg, cur_prio_next;
    logic              cur_valid_reg, cur_valid_next;
    logic              started_reg, started_next;
    logic [15:0]       sw_cnt_reg, sw_cnt_next;

    // per-request result
    status_t           status_reg, status_next;
    logic              switched_reg, switched_next;
    logic              save_reg, save_next;
    logic [SLOT_W-1:0] created_reg, created_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // ready queue entries one and up, each {slot, priority}
    logic [ENT_W-1:0]  order_mem [TASK_SLOTS];
    logic [ENT_W-1:0]  q_reg;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [ENT_W-1:0]  mem_wdata;

    logic [CNT_W-1:0]  idx_m1;
    logic [CNT_W-1:0]  idx_p1;
    logic [SLOT_W-1:0] src_slot;
    logic [7:0]        src_prio;
    logic              create_ok;
    logic              delay_ok;
    logic              do_switch;
    logic [SLOT_W+2:0] cur_ext;
    logic [SLOT_W+2:0] created_ext;

    assign idx_m1 = idx_reg - ONE_C;
    assign idx_p1 = idx_reg + ONE_C;

    // the entry read for an insertion step sits at idx - 1, which is the head when idx is one
    assign src_slot = (idx_reg == ONE_C) ? head_slot_reg : q_reg[ENT_W-1:8];
    assign src_prio = (idx_reg == ONE_C) ? head_prio_reg : q_reg[7:0];

    assign create_ok = (mode_reg == MODE_CREATE) && (free_reg < SLOTS_C) && (count_reg < SLOTS_C);
    assign delay_ok  = (mode_reg == MODE_DELAY) && (ticks_reg != 16'd0) && (count_reg > ONE_C);
    assign do_switch = !(cur_valid_reg && (head_prio_reg == cur_prio_reg));

    assign stat.create_ok = create_ok;
    assign stat.delay_ok  = delay_ok;
    assign stat.is_run    = (mode_reg == MODE_RUN);
    assign stat.idx_zero  = (idx_reg == '0);
    assign stat.shift_on  = (src_prio >= prio_reg);
    assign stat.dly_last  = (idx_p1 == count_reg);
    assign stat.started   = started_reg;
    assign stat.out_free  = !m_tvalid_reg || m_axis_tready;

    assign rd_en   = (cmd.ins_read && (idx_reg != '0)) || cmd.dly_read;
    assign rd_addr = cmd.ins_read ? idx_m1[SLOT_W-1:0] : idx_reg[SLOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            order_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            q_reg <= order_mem[rd_addr];
        end
    end

    assign cur_ext     = {3'b000, cur_slot_reg};
    assign created_ext = {3'b000, created_reg};

    always_comb begin
        idx_next       = idx_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        head_slot_next = head_slot_reg;
        head_prio_next = head_prio_reg;
        new_slot_next  = new_slot_reg;
        cur_slot_next  = cur_slot_reg;
        cur_prio_next  = cur_prio_reg;
        cur_valid_next = cur_valid_reg;
        started_next   = started_reg;
        sw_cnt_next    = sw_cnt_reg;
        status_next    = status_reg;
        switched_next  = switched_reg;
        save_next      = save_reg;
        created_next   = created_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[SLOT_W-1:0];
        mem_wdata      = {src_slot, src_prio};

        if (cmd.dispatch) begin
            status_next   = STAT_OK;
            switched_next = 1'b0;
            save_next     = 1'b0;
            created_next  = '0;
            case (mode_reg)
                MODE_CREATE: begin
                    if (create_ok) begin
                        new_slot_next = free_reg[SLOT_W-1:0];
                        created_next  = free_reg[SLOT_W-1:0];
                        free_next     = free_reg + ONE_C;
                        idx_next      = count_reg;
                        count_next    = count_reg + ONE_C;
                    end else begin
                        status_next = STAT_NO_SLOT;
                    end
                end
                MODE_DELAY: begin
                    if (ticks_reg == 16'd0) begin
                        status_next = STAT_ZERO_DELAY;
                    end else if (count_reg <= ONE_C) begin
                        status_next = STAT_QUEUE_EMPTY;
                    end else begin
                        idx_next = ONE_C;
                    end
                end
                MODE_RUN: begin
                    started_next = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // new task reaches the front of the queue
        if (cmd.ins_read && (idx_reg == '0)) begin
            head_slot_next = new_slot_reg;
            head_prio_next = prio_reg;
        end

        if (cmd.ins_step) begin
            mem_we = 1'b1;
            if (src_prio >= prio_reg) begin
                idx_next = idx_m1;
            end else begin
                mem_wdata = {new_slot_reg, prio_reg};
            end
        end

        // pull entry idx forward to idx - 1
        if (cmd.dly_step) begin
            if (idx_reg == ONE_C) begin
                head_slot_next = q_reg[ENT_W-1:8];
                head_prio_next = q_reg[7:0];
            end else begin
                mem_we    = 1'b1;
                mem_waddr = idx_m1[SLOT_W-1:0];
                mem_wdata = q_reg;
            end
            idx_next = idx_p1;
            if (idx_p1 == count_reg) begin
                count_next = count_reg - ONE_C;
            end
        end

        if (cmd.sched && do_switch) begin
            switched_next  = 1'b1;
            save_next      = (nest_reg == 8'd0) && cur_valid_reg;
            sw_cnt_next    = sw_cnt_reg + 16'd1;
            cur_slot_next  = head_slot_reg;
            cur_prio_next  = head_prio_reg;
            cur_valid_next = 1'b1;
        end

        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'b0_0000, sw_cnt_reg, created_ext[2:0], cur_valid_reg,
                             cur_ext[2:0], save_reg, switched_reg, status_reg};
        end else if (m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= ONE_C;
            free_reg      <= ONE_C;
            head_slot_reg <= '0;
            head_prio_reg <= IDLE_C;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            sw_cnt_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            count_reg     <= count_next;
            free_reg      <= free_next;
            head_slot_reg <= head_slot_next;
            head_prio_reg <= head_prio_next;
            cur_slot_reg  <= cur_slot_next;
            cur_valid_reg <= cur_valid_next;
            started_reg   <= started_next;
            sw_cnt_reg    <= sw_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= mode_t'(in_tuser[1:0]);
            prio_reg  <= in_tdata[7:0];
            ticks_reg <= in_tdata[23:8];
            nest_reg  <= in_tdata[31:24];
        end
        idx_reg      <= idx_next;
        new_slot_reg <= new_slot_next;
        cur_prio_reg <= cur_prio_next;
        status_reg   <= status_next;
        switched_reg <= switched_next;
        save_reg     <= save_next;
        created_reg  <= created_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

// ----- hdl/priority_ready_queue_scheduler.sv -----
// Path, transfer in to result out: a refused or ignored request goes straight to the output register,
// a run schedules first, a create moves entries back one at a time (or lands at the head) and
// then schedules if the kernel is started, and a delay pulls entries forward one at a time.
// Throughput: one request at a time, paced by the queue walk through the single-port memory;
// the next request is taken the cycle after a result enters the output register.
// Reset: synchronous, active low; idle task alone in the queue, kernel stopped, no clearing pass.
module priority_ready_queue_scheduler #(
    parameter int TASK_SLOTS    = prqs_pkg::TASK_SLOTS_DEF,
    parameter int IDLE_PRIORITY = prqs_pkg::IDLE_PRIORITY_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // task_priority[7:0], delay_ticks[23:8], nesting_level[31:24]
    input  logic [prqs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [prqs_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status[1:0], switched[2], save_context[3], running_slot[6:4], running_valid[7],
    // created_slot[10:8], switch_total[26:11], zero[31:27]
    output logic [prqs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import prqs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    prqs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    prqs_datapath #(
        .TASK_SLOTS    (TASK_SLOTS),
        .IDLE_PRIORITY (IDLE_PRIORITY)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_tdata      (s_axis_tdata),
        .in_tuser      (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // one request in flight: no new transfer straight after one is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken twice in a row");

    // the outgoing context is only saved on a switch
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[3]) |-> m_axis_tdata[2])
        else $error("save_context without switch");

    // after a switch some task is running
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[2]) |-> m_axis_tdata[7])
        else $error("switch left no running task");

    // a refused create assigns no slot and does not switch
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tdata[1:0] == STAT_NO_SLOT))
            |-> ((m_axis_tdata[10:8] == 3'd0) && !m_axis_tdata[2]))
        else $error("refused create changed state");

endmodule
